// ----- rtl/spi_pkg.sv -----
// package for the smoothstep pose interpolator
// shared constants and types; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spi_pkg;
   localparam int CmdChannels  = 9;
   localparam int PoseChannels = 6;
   localparam int ValueWidth   = 32;
   localparam int StepWidth    = 16;
   localparam int RatioWidth   = 17;
   localparam logic [StepWidth-1:0] StepCountReset = 16'd300;
   localparam logic [RatioWidth-1:0] RatioOne = 17'h10000;

   localparam logic [1:0] CMD_POSE   = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef value_type [CmdChannels-1:0] vec_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_SQ    = 5'b00100,
      ST_CUBE  = 5'b01000,
      ST_BLEND = 5'b10000
   } state_type;

   typedef struct packed {
      logic                  go;
      logic                  last;
      logic [RatioWidth-1:0] ratio;
   } lane_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/smoothstep_pose_interpolator_unit.sv -----
// top level of the smoothstep pose interpolator: control, state and lanes
// depends on spi_pkg, spi_div, spi_lane
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | contents
// req_    | in        | tuser cmd, tdata channel_value_0..8
// rsp_    | out       | tdata setpoint_0..8, tlast final_step
// csr_    | in        | step_count write
// pose and target transactions are taken in the idle state; a non-final tick passes
// through the bit-serial ratio divider (32 steps), then two ratio multiplies and the
// lane blend before its result is registered; a final tick goes straight to the blend.
// reset is synchronous; step_count returns to 300.
// a result waits in the output register; the input stalls until it is taken.
module smoothstep_pose_interpolator_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [287:0] req_tdata,   // channel_value_0 .. channel_value_8
   input  wire  [1:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [287:0] rsp_tdata,   // setpoint_0 .. setpoint_8
   output logic         rsp_tlast,   // final_step
   input  wire          csr_wen,
   input  wire  [15:0]  csr_wdata
);
   localparam int N = spi_pkg::CmdChannels;
   localparam int P = spi_pkg::PoseChannels;

   spi_pkg::state_type state_ff, state_in;
   logic [15:0] count_ff, step_ff, step_in, count_eff, next_step;
   logic pose_known_ff, prev_known_ff, moving_ff, last_ff, last_in;
   spi_pkg::vec_type pose_ff, prev_ff, start_ff, target_ff, req_vec, lane_out;
   logic [16:0] t_ff, s_ff, s_in, quot;
   logic [33:0] sq;
   logic [17:0] fac;
   logic [34:0] cube;
   logic div_go, div_done, accept, full_ff, full_in;
   spi_pkg::lane_ctl_type ctl;

   for (genvar i = 0; i < N; i++) begin : g_lane
      assign req_vec[i] = req_tdata[32*i +: 32];
      assign rsp_tdata[32*i +: 32] = lane_out[i];
      spi_lane u_lane (.clock(clock), .ctl(ctl), .start(start_ff[i]),
                       .target(target_ff[i]), .result(lane_out[i]));
   end

   assign count_eff  = (count_ff == 16'd0) ? 16'd1 : count_ff;
   assign next_step  = step_ff + 16'd1;
   assign req_tready = (state_ff == spi_pkg::ST_IDLE) && !full_ff;
   assign accept     = req_tvalid && req_tready;
   assign div_go     = accept && req_tuser == spi_pkg::CMD_TICK && moving_ff
                       && (17'(next_step) < 17'(count_eff));
   assign sq   = 34'(t_ff) * 34'(t_ff);
   assign fac  = 18'(3 * 65536) - {t_ff, 1'b0};
   assign cube = 35'(s_ff) * 35'(fac);

   spi_div u_div (.clock(clock), .reset(reset), .start(div_go), .step(next_step),
                  .count(count_eff), .done(div_done), .quot(quot));

   always_comb begin
      state_in = state_ff; step_in = step_ff; s_in = s_ff; last_in = last_ff;
      full_in  = full_ff && !rsp_tready;
      ctl.go = 1'b0; ctl.last = last_ff; ctl.ratio = s_ff;
      case (state_ff)
         spi_pkg::ST_IDLE: begin
            if (accept && req_tuser == spi_pkg::CMD_TICK && moving_ff) begin
               if (div_go) begin
                  state_in = spi_pkg::ST_DIV; last_in = 1'b0; step_in = next_step;
               end else begin
                  state_in = spi_pkg::ST_BLEND; last_in = 1'b1; step_in = '0;
                  s_in = spi_pkg::RatioOne;
               end
            end else if (accept && req_tuser == spi_pkg::CMD_TARGET && !moving_ff) begin
               step_in = '0;
            end
         end
         spi_pkg::ST_DIV:  if (div_done) state_in = spi_pkg::ST_SQ;
         spi_pkg::ST_SQ: begin
            s_in = sq[32:16]; state_in = spi_pkg::ST_CUBE;
         end
         spi_pkg::ST_CUBE: begin
            s_in = cube[32:16]; state_in = spi_pkg::ST_BLEND;
         end
         spi_pkg::ST_BLEND: begin
            ctl.go = 1'b1; full_in = 1'b1; state_in = spi_pkg::ST_IDLE;
         end
         default: state_in = spi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spi_pkg::ST_IDLE;
         count_ff <= spi_pkg::StepCountReset;
         step_ff <= '0; pose_known_ff <= 1'b0; prev_known_ff <= 1'b0;
         moving_ff <= 1'b0; full_ff <= 1'b0; last_ff <= 1'b0;
         pose_ff <= '0; prev_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; full_ff <= full_in;
         last_ff <= last_in;
         if (csr_wen) count_ff <= csr_wdata;
         if (accept && req_tuser == spi_pkg::CMD_POSE) begin
            for (int i = 0; i < P; i++) pose_ff[i] <= req_vec[i];
            pose_known_ff <= 1'b1;
         end
         if (accept && req_tuser == spi_pkg::CMD_TARGET && !moving_ff) begin
            moving_ff <= 1'b1;
         end
         if (state_ff == spi_pkg::ST_BLEND && last_ff) begin
            prev_ff <= target_ff; prev_known_ff <= 1'b1; moving_ff <= 1'b0;
         end
      end
      s_ff <= s_in;
      if (state_ff == spi_pkg::ST_DIV && div_done) t_ff <= quot;
      if (accept && req_tuser == spi_pkg::CMD_TARGET && !moving_ff) begin
         target_ff <= req_vec;
         for (int i = 0; i < N; i++) begin
            if (i < P) begin
               start_ff[i] <= pose_known_ff ? pose_ff[i]
                              : (prev_known_ff ? prev_ff[i] : req_vec[i]);
            end else begin
               start_ff[i] <= prev_known_ff ? prev_ff[i] : '0;
            end
         end
      end
      if (state_ff == spi_pkg::ST_BLEND) rsp_tlast <= last_ff;
   end

   assign rsp_tvalid = full_ff;
endmodule
`default_nettype wire

// ----- rtl/spi_lane.sv -----
// one channel lane: start + trunc((target - start) * s)
// depends on spi_pkg
`timescale 1ns / 1ps
`default_nettype none
module spi_lane (
   input  wire                        clock,
   input  wire spi_pkg::lane_ctl_type ctl,
   input  wire spi_pkg::value_type    start,
   input  wire spi_pkg::value_type    target,
   output spi_pkg::value_type         result
);
   logic signed [32:0] diff;
   logic        [32:0] mag;
   logic        [49:0] prod;
   logic        [32:0] part;
   spi_pkg::value_type result_ff, result_in;

   always_comb begin
      diff = 33'(signed'(target)) - 33'(signed'(start));
      mag  = diff[32] ? 33'(-diff) : diff;
      prod = 50'(mag) * 50'(ctl.ratio);
      part = prod[48:16];
      if (ctl.last) begin
         result_in = target;
      end else if (diff[32]) begin
         result_in = spi_pkg::value_type'(33'(signed'(start)) - signed'(part));
      end else begin
         result_in = spi_pkg::value_type'(33'(signed'(start)) + signed'(part));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.go) begin
         result_ff <= result_in;
      end
   end
   assign result = result_ff;
endmodule
`default_nettype wire

// ----- rtl/spi_div.sv -----
// bit-serial divider: floor((step << 16) / count), 17-bit quotient
// depends on spi_pkg
`timescale 1ns / 1ps
`default_nettype none
module spi_div (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire [spi_pkg::StepWidth-1:0]      step,
   input  wire [spi_pkg::StepWidth-1:0]      count,
   output logic                              done,
   output logic [spi_pkg::RatioWidth-1:0]    quot
);
   localparam int NumWidth = spi_pkg::StepWidth + 16;
   logic [NumWidth-1:0] num_ff, num_in;
   logic [spi_pkg::StepWidth:0] rem_ff, rem_in, trial;
   logic [spi_pkg::RatioWidth-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial  = {rem_ff[spi_pkg::StepWidth-1:0], num_ff[NumWidth-1]};
      if (start) begin
         num_in  = {step, 16'd0};
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 6'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumWidth-2:0], 1'b0};
         if (trial >= {1'b0, count}) begin
            rem_in = trial - {1'b0, count};
            q_in   = {q_ff[spi_pkg::RatioWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[spi_pkg::RatioWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end
   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- sim/smoothstep_pose_interpolator_checker.sv -----
// checker for the smoothstep pose interpolator: watches the request, result and csr
// channels, predicts every setpoint and compares; depends on spi_pkg
`timescale 1ns / 1ps
module smoothstep_pose_interpolator_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [287:0] req_tdata,
   input  wire  [1:0]   req_tuser,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [287:0] rsp_tdata,
   input  wire          rsp_tlast,
   input  wire          csr_wen,
   input  wire  [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending_setpoints
);
   typedef struct {
      logic [287:0] setpoints;
      logic         final_flag;
   } setpoint_type;

   setpoint_type    setpoint_queue[$];
   logic [15:0]     count_reg;
   logic signed [31:0] pose_meas[spi_pkg::PoseChannels];
   logic            pose_valid;
   logic signed [31:0] last_cmd[spi_pkg::CmdChannels];
   logic            last_valid;
   logic signed [31:0] start_pt[spi_pkg::CmdChannels];
   logic signed [31:0] goal_pt[spi_pkg::CmdChannels];
   logic [15:0]     step_pos;
   logic            in_motion;

   assign pending_setpoints = setpoint_queue.size();

   function automatic logic signed [31:0] blend_value(logic signed [31:0] from,
                                                       logic signed [31:0] to,
                                                       logic [63:0] ratio);
      logic signed [63:0] diff;
      logic [63:0] mag;
      logic [63:0] part;
      diff = 64'(to) - 64'(from);
      mag  = diff < 0 ? 64'(-diff) : 64'(diff);
      part = (mag * ratio) >> 16;
      return diff < 0 ? 32'(64'(from) - part) : 32'(64'(from) + part);
   endfunction

   task automatic take_request(logic [1:0] kind, logic [287:0] values);
      setpoint_type sp;
      logic [63:0] cnt, stp, t, t2, s;
      logic signed [31:0] tv;
      logic last;
      if (kind == spi_pkg::CMD_POSE) begin
         for (int i = 0; i < spi_pkg::PoseChannels; i++)
            pose_meas[i] = values[32*i +: 32];
         pose_valid = 1'b1;
      end else if (kind == spi_pkg::CMD_TARGET && !in_motion) begin
         for (int i = 0; i < spi_pkg::CmdChannels; i++) begin
            tv = values[32*i +: 32];
            goal_pt[i] = tv;
            if (i < spi_pkg::PoseChannels)
               start_pt[i] = pose_valid ? pose_meas[i]
                             : (last_valid ? last_cmd[i] : tv);
            else
               start_pt[i] = last_valid ? last_cmd[i] : 32'sd0;
         end
         step_pos  = '0;
         in_motion = 1'b1;
      end else if (kind == spi_pkg::CMD_TICK && in_motion) begin
         cnt  = count_reg == 0 ? 64'd1 : 64'(count_reg);
         stp  = 64'(step_pos) + 1;
         last = stp >= cnt;
         if (last) s = 64'd65536;
         else begin
            t  = (stp << 16) / cnt;
            t2 = (t * t) >> 16;
            s  = (t2 * (3 * 64'd65536 - 2 * t)) >> 16;
         end
         for (int i = 0; i < spi_pkg::CmdChannels; i++)
            sp.setpoints[32*i +: 32] = last ? goal_pt[i]
                                       : blend_value(start_pt[i], goal_pt[i], s);
         sp.final_flag = last;
         setpoint_queue.push_back(sp);
         if (last) begin
            for (int i = 0; i < spi_pkg::CmdChannels; i++) last_cmd[i] = goal_pt[i];
            last_valid = 1'b1;
            in_motion  = 1'b0;
            step_pos   = '0;
         end else step_pos = stp[15:0];
      end
   endtask

   always @(posedge clock) begin
      setpoint_type exp_sp;
      if (reset) begin
         count_reg  = spi_pkg::StepCountReset;
         pose_valid = 1'b0;
         last_valid = 1'b0;
         in_motion  = 1'b0;
         step_pos   = '0;
         for (int i = 0; i < spi_pkg::PoseChannels; i++) pose_meas[i] = '0;
         for (int i = 0; i < spi_pkg::CmdChannels; i++) last_cmd[i] = '0;
         setpoint_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (setpoint_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected setpoint %h", rsp_tdata);
            end else begin
               exp_sp = setpoint_queue.pop_front();
               if (rsp_tdata !== exp_sp.setpoints || rsp_tlast !== exp_sp.final_flag) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("setpoint exp %h last %b, got %h last %b",
                              exp_sp.setpoints, exp_sp.final_flag, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
         if (csr_wen) count_reg = csr_wdata;
      end
   end
endmodule

// ----- sim/smoothstep_pose_interpolator_unit_tb.sv -----
// testbench top for the smoothstep pose interpolator: clock, reset, stimulus, verdict
// depends on spi_pkg, the rtl and smoothstep_pose_interpolator_checker
`timescale 1ns / 1ps
module smoothstep_pose_interpolator_unit_tb;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic [1:0]   req_tuser = spi_pkg::CMD_POSE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [287:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wen = 1'b0;
   logic [15:0]  csr_wdata = '0;
   int           fail_count;
   int           pending_setpoints;
   int           hold_cycles = 0;
   int           rsp_wait = 0;
   bit           stall_free = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   smoothstep_pose_interpolator_unit u_dut (.*);

   smoothstep_pose_interpolator_checker u_checker (.*);

   // result side: a random wait per transaction unless stall_free is set, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) rsp_wait = stall_free ? 0 : $urandom_range(0, 11);
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         3: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic [1:0] kind, logic [287:0] values, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      repeat (gap) @(negedge clock);
      req_tuser  <= kind;
      req_tdata  <= values;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic send_random(logic [1:0] kind);
      logic [287:0] v;
      for (int i = 0; i < spi_pkg::CmdChannels; i++) v[32*i +: 32] = pick_value();
      send(kind, v, 1'b0);
   endtask

   task automatic drain_and_write(logic [15:0] count);
      while (pending_setpoints != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= count;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // one move of n ticks with a few stray items mixed in
   task automatic run_move(int ticks);
      send_random(spi_pkg::CMD_TARGET);
      for (int k = 0; k < ticks; k++) begin
         case ($urandom_range(0, 15))
            0: send_random(spi_pkg::CMD_POSE);
            1: send_random(spi_pkg::CMD_TARGET);
            2: send_random(CMD_UNKNOWN);
            default: ;
         endcase
         send_random(spi_pkg::CMD_TICK);
      end
   endtask

   initial begin
      logic [287:0] ext;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      // directed: tick while idle, target with nothing known, extremes
      send_random(spi_pkg::CMD_TICK);
      drain_and_write(16'd3);
      for (int i = 0; i < spi_pkg::CmdChannels; i++)
         ext[32*i +: 32] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      send(spi_pkg::CMD_TARGET, ext, 1'b0);
      repeat (3) send(spi_pkg::CMD_TICK, '0, 1'b0);
      for (int i = 0; i < spi_pkg::CmdChannels; i++)
         ext[32*i +: 32] = (i % 2) ? 32'h7fffffff : 32'h80000000;
      send(spi_pkg::CMD_TARGET, ext, 1'b0);
      send(spi_pkg::CMD_TARGET, '1, 1'b0);
      send(spi_pkg::CMD_POSE, '1, 1'b0);
      repeat (3) send(spi_pkg::CMD_TICK, '0, 1'b0);
      send(spi_pkg::CMD_POSE, ext, 1'b0);
      send(spi_pkg::CMD_TARGET, ~ext, 1'b0);
      send(CMD_UNKNOWN, '1, 1'b0);
      send(spi_pkg::CMD_TICK, '0, 1'b0);
      drain_and_write(16'd0);
      run_move(1);
      drain_and_write(16'd1);
      run_move(2);
      // count lowered during a move
      drain_and_write(16'd10);
      run_move(3);
      drain_and_write(16'd2);
      run_move(2);
      // long receiver hold-off while requests keep coming
      drain_and_write(16'd20);
      hold_cycles = 400;
      send_random(spi_pkg::CMD_TARGET);
      repeat (8) send(spi_pkg::CMD_TICK, '0, 1'b1);
      run_move(12);
      // random phases
      for (int ph = 0; ph < 12; ph++) begin
         drain_and_write(ph == 11 ? 16'hffff : 16'($urandom_range(1, 12)));
         stall_free = (ph % 4 == 3);
         for (int m = 0; m < 10; m++) run_move($urandom_range(1, 12));
      end
      stall_free = 1;
      drain_and_write(16'd300);
      repeat (20) send_random(spi_pkg::CMD_TICK);
      while (pending_setpoints != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) $display("smoothstep_pose_interpolator_unit: match");
      else $display("smoothstep_pose_interpolator_unit: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("smoothstep_pose_interpolator_unit: mismatch");
      $finish;
   end
endmodule
